FILE: design/iq_fir_decimator_defines.svh
// Assertion macros shared by the iq_fir_decimator checkers.
`ifndef IQ_FIR_DECIMATOR_DEFINES_SVH
`define IQ_FIR_DECIMATOR_DEFINES_SVH

// property checked on every clock edge outside reset
`define IQFD_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every clock edge, reset included
`define IQFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/iqfd_pkg.sv
// Constants, kernel table and coefficient scaling for the I/Q FIR decimator.
package iqfd_pkg;

   localparam int SAMPLE_W   = 8;
   localparam int KERNEL_LEN = 15;
   localparam int E4_SCALE   = 10000;
   localparam int E4_HALF    = 5000;
   localparam int OFFSET     = 128;
   localparam int BYTE_MAX   = 255;

   typedef int kernel_type [KERNEL_LEN];

   // low-pass kernel in units of 1e-4
   localparam kernel_type KERNEL_E4 = '{
      -101, -175, -39, 381, 1042, 1741, 2227, 2393,
      2227, 1741, 1042, 381, -39, -175, -101
   };

   // tap k scaled by 2^frac_bits, nearest with ties away from zero; zero past the kernel
   function automatic longint coef_value(int k, int frac_bits);
      longint mag;
      longint q;
      if (k >= KERNEL_LEN) begin
         return 0;
      end else begin
         mag = (KERNEL_E4[k] < 0) ? longint'(-KERNEL_E4[k]) : longint'(KERNEL_E4[k]);
         q   = ((mag << frac_bits) + longint'(E4_HALF)) / E4_SCALE;
         return (KERNEL_E4[k] < 0) ? -q : q;
      end
   endfunction

endpackage

FILE: design/iqfd_if.sv
// Request and response channel interfaces of the I/Q FIR decimator.
interface iqfd_req_if;
   logic                            valid;
   logic                            ready;
   logic [iqfd_pkg::SAMPLE_W-1:0]   i_sample;
   logic [iqfd_pkg::SAMPLE_W-1:0]   q_sample;

   modport source (output valid, i_sample, q_sample, input ready);
   modport sink (input valid, i_sample, q_sample, output ready);
endinterface

interface iqfd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [iqfd_pkg::SAMPLE_W-1:0]   i_out;
   logic [iqfd_pkg::SAMPLE_W-1:0]   q_out;

   modport source (output valid, i_out, q_out, input ready);
   modport sink (input valid, i_out, q_out, output ready);
endinterface

FILE: design/iqfd_tap_cell.sv
// One transposed-form FIR tap for both channels: product plus neighbor's partial sum.
module iqfd_tap_cell #(
   parameter int                           COEF_BITS = 16,
   parameter int                           ACC_W     = 32,
   parameter logic signed [COEF_BITS-1:0]  COEF      = '0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             shift_en,
   input  logic signed [iqfd_pkg::SAMPLE_W-1:0] x_i,
   input  logic signed [iqfd_pkg::SAMPLE_W-1:0] x_q,
   input  logic signed [ACC_W-1:0]          from_next_i,
   input  logic signed [ACC_W-1:0]          from_next_q,
   output logic signed [ACC_W-1:0]          part_i,
   output logic signed [ACC_W-1:0]          part_q
);

   localparam int PROD_W = COEF_BITS + iqfd_pkg::SAMPLE_W;

   logic signed [PROD_W-1:0] prod_i;
   logic signed [PROD_W-1:0] prod_q;
   logic signed [ACC_W-1:0]  part_i_in;
   logic signed [ACC_W-1:0]  part_q_in;
   logic signed [ACC_W-1:0]  part_i_ff;
   logic signed [ACC_W-1:0]  part_q_ff;

   assign prod_i    = x_i * COEF;
   assign prod_q    = x_q * COEF;
   assign part_i_in = ACC_W'(prod_i) + from_next_i;
   assign part_q_in = ACC_W'(prod_q) + from_next_q;

   always_ff @(posedge clock) begin
      if (reset) begin
         part_i_ff <= '0;
         part_q_ff <= '0;
      end else if (shift_en) begin
         part_i_ff <= part_i_in;
         part_q_ff <= part_q_in;
      end
   end

   assign part_i = part_i_ff;
   assign part_q = part_q_ff;

endmodule

FILE: design/iqfd_out_stage.sv
// Head tap, accumulator register, floor/offset/clamp and response register.
module iqfd_out_stage #(
   parameter int                           COEF_BITS = 16,
   parameter int                           ACC_W     = 32,
   parameter logic signed [COEF_BITS-1:0]  COEF      = '0
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             load,
   input  logic signed [iqfd_pkg::SAMPLE_W-1:0] x_i,
   input  logic signed [iqfd_pkg::SAMPLE_W-1:0] x_q,
   input  logic signed [ACC_W-1:0]          part_i,
   input  logic signed [ACC_W-1:0]          part_q,
   output logic                             free,
   iqfd_rsp_if.source                       rsp
);

   localparam int PROD_W    = COEF_BITS + iqfd_pkg::SAMPLE_W;
   localparam int FRAC_BITS = COEF_BITS - 1;

   logic signed [PROD_W-1:0]            prod_i;
   logic signed [PROD_W-1:0]            prod_q;
   logic signed [ACC_W-1:0]             acc_i_in;
   logic signed [ACC_W-1:0]             acc_q_in;
   logic signed [ACC_W-1:0]             acc_i_ff;
   logic signed [ACC_W-1:0]             acc_q_ff;
   logic                                held_in;
   logic                                held_ff;
   logic                                out_valid_in;
   logic                                out_valid_ff;
   logic [iqfd_pkg::SAMPLE_W-1:0]       i_out_ff;
   logic [iqfd_pkg::SAMPLE_W-1:0]       q_out_ff;
   logic                                move;

   function automatic logic [iqfd_pkg::SAMPLE_W-1:0] to_byte(logic signed [ACC_W-1:0] acc);
      logic signed [ACC_W-1:0] v;
      v = (acc >>> FRAC_BITS) + ACC_W'(iqfd_pkg::OFFSET);
      if (v < 0) begin
         return '0;
      end else if (v > ACC_W'(iqfd_pkg::BYTE_MAX)) begin
         return iqfd_pkg::SAMPLE_W'(iqfd_pkg::BYTE_MAX);
      end else begin
         return iqfd_pkg::SAMPLE_W'(v);
      end
   endfunction

   assign prod_i   = x_i * COEF;
   assign prod_q   = x_q * COEF;
   assign acc_i_in = ACC_W'(prod_i) + part_i;
   assign acc_q_in = ACC_W'(prod_q) + part_q;

   assign move         = held_ff && (!out_valid_ff || rsp.ready);
   assign free         = !held_ff || move;
   assign held_in      = load ? 1'b1 : (move ? 1'b0 : held_ff);
   assign out_valid_in = move ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         held_ff      <= held_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         acc_i_ff <= acc_i_in;
         acc_q_ff <= acc_q_in;
      end
      if (move) begin
         i_out_ff <= to_byte(acc_i_ff);
         q_out_ff <= to_byte(acc_q_ff);
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.i_out = i_out_ff;
   assign rsp.q_out = q_out_ff;

endmodule

FILE: design/iq_fir_decimator.sv
// Top level of the I/Q FIR decimator: phase counter and chain of tap cells.
//
//   channel   dir   handshake       payload
//   req_ch    in    valid / ready   i_sample, q_sample (offset-binary bytes)
//   rsp_ch    out   valid / ready   i_out, q_out (offset-binary bytes)
//
// One request per cycle while ready is high; every DECIM-th request yields one response.
// A firing request passes the accumulator register, then clamp and the output register.
// Each tap cell adds its product into the partial sum from its neighbor on every request.
// Synchronous reset clears the partial sums, the phase counter and both valid flags.
// A stalled response holds; requests that yield no response are taken while it waits.
module iq_fir_decimator #(
   parameter int TAPS      = 15,
   parameter int DECIM     = 4,
   parameter int COEF_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   iqfd_req_if.sink     req_ch,
   iqfd_rsp_if.source   rsp_ch
);

   localparam int SW        = iqfd_pkg::SAMPLE_W;
   localparam int FRAC_BITS = COEF_BITS - 1;
   localparam int ACC_W     = COEF_BITS + SW + $clog2(TAPS + 1);
   localparam int PH_W      = (DECIM > 1) ? $clog2(DECIM) : 1;

   logic signed [SW-1:0]    x_i;
   logic signed [SW-1:0]    x_q;
   logic                    accept;
   logic                    fire;
   logic                    stage_free;
   logic [PH_W-1:0]         phase_in;
   logic [PH_W-1:0]         phase_ff;
   logic signed [ACC_W-1:0] part_i [1:TAPS];
   logic signed [ACC_W-1:0] part_q [1:TAPS];

   // subtract the offset: flip the top bit
   assign x_i = {~req_ch.i_sample[SW-1], req_ch.i_sample[SW-2:0]};
   assign x_q = {~req_ch.q_sample[SW-1], req_ch.q_sample[SW-2:0]};

   assign fire         = (phase_ff == PH_W'(DECIM - 1));
   assign req_ch.ready = stage_free || !fire;
   assign accept       = req_ch.valid && req_ch.ready;
   assign phase_in     = fire ? '0 : phase_ff + PH_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
      end
   end

   assign part_i[TAPS] = '0;
   assign part_q[TAPS] = '0;

   for (genvar k = 1; k < TAPS; k++) begin : g_tap
      iqfd_tap_cell #(
         .COEF_BITS (COEF_BITS),
         .ACC_W     (ACC_W),
         .COEF      (COEF_BITS'(iqfd_pkg::coef_value(k, FRAC_BITS)))
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift_en    (accept),
         .x_i         (x_i),
         .x_q         (x_q),
         .from_next_i (part_i[k+1]),
         .from_next_q (part_q[k+1]),
         .part_i      (part_i[k]),
         .part_q      (part_q[k])
      );
   end

   iqfd_out_stage #(
      .COEF_BITS (COEF_BITS),
      .ACC_W     (ACC_W),
      .COEF      (COEF_BITS'(iqfd_pkg::coef_value(0, FRAC_BITS)))
   ) u_out (
      .clock  (clock),
      .reset  (reset),
      .load   (accept && fire),
      .x_i    (x_i),
      .x_q    (x_q),
      .part_i (part_i[1]),
      .part_q (part_q[1]),
      .free   (stage_free),
      .rsp    (rsp_ch)
   );

endmodule

FILE: design/iqfd_checker.sv
// Port-level checker for the I/Q FIR decimator, bound to the top level.
`include "iq_fir_decimator_defines.svh"

module iqfd_port_checks (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [iqfd_pkg::SAMPLE_W-1:0]   i_out,
   input logic [iqfd_pkg::SAMPLE_W-1:0]   q_out
);

   logic req_accept;

   assign req_accept = req_valid && req_ready;

   `IQFD_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(i_out) && $stable(q_out), "response changed while stalled")
   `IQFD_ASSERT(a_rsp_drop, clock, reset, $fell(rsp_valid) |-> $past(rsp_ready) || $past(reset), "response dropped without handshake")
   `IQFD_ASSERT(a_rsp_src, clock, reset, $rose(rsp_valid) |-> $past(req_accept, 2), "response without request two cycles earlier")
   `IQFD_ASSERT_ALWAYS(a_rst_idle, clock, $past(reset) |-> !rsp_valid, "response valid after reset")

endmodule

bind iq_fir_decimator iqfd_port_checks u_iqfd_port_checks (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .i_out     (rsp_ch.i_out),
   .q_out     (rsp_ch.q_out)
);
